>>> src/ltmc_pkg.sv
// Package for the line tracking mode controller: mode codes, command codes,
// register indexes and the payload structs. No dependencies.
package ltmc_pkg;

    typedef enum logic [6:0] {
        M_STRAIGHT = 7'd10, M_DRIFT_R = 7'd11, M_DRIFT_L = 7'd12,
        M_RA_BRAKE = 7'd21, M_RA_WAIT = 7'd22, M_RA_FIND = 7'd23,
        M_RA_LEFT = 7'd26, M_RA_RIGHT = 7'd27, M_SPIN_L = 7'd31, M_SEEK_L = 7'd32,
        M_SPIN_R = 7'd41, M_SEEK_R = 7'd42, M_LC_L = 7'd51, M_LC_L_GO = 7'd52,
        M_LC_L_SET = 7'd53, M_LC_R = 7'd61, M_LC_R_GO = 7'd62, M_LC_R_SET = 7'd63,
        M_LOST = 7'd73, M_BRIDGE = 7'd99
    } t_mode;

    typedef enum logic [1:0] {
        CMD_STEP = 2'd0, CMD_TICK = 2'd1, CMD_PULSE = 2'd2, CMD_NONE = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_DELAY  = 2'd0;
    localparam logic [1:0] REG_BRIDGE = 2'd1;
    localparam logic [1:0] REG_HOLD   = 2'd2;

    localparam int STEER_TRIM = 5;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] line_sensors;
        logic       fast_flag;
        logic       settled_flag;
    } t_item;

    typedef struct packed {
        logic [6:0]        mode_code;
        logic              steer_set;
        logic signed [8:0] steer_angle;
        logic              drive_set;
        logic signed [7:0] left_drive;
        logic signed [7:0] right_drive;
        logic              target_set;
        logic signed [4:0] speed_target;
    } t_result;

    typedef struct packed {
        logic [7:0]  delay_factor;
        logic [15:0] bridge_limit;
        logic [15:0] turn_hold;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  mode;
        logic [15:0] tick_count;
        logic [15:0] pulse_count;
        logic [15:0] bridge_count;
    } t_state;

endpackage

>>> src/ltmc_step.sv
// Combinational next-state and result logic for one beat.
// Depends on ltmc_pkg.
module ltmc_step import ltmc_pkg::*; (
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    output t_state  o_state,
    output t_result o_result
);

    logic [7:0]  s;
    logic [23:0] settle_lim;

    function automatic void set_steer(input logic signed [8:0] a);
        o_result.steer_set = 1'b1; o_result.steer_angle = a;
    endfunction

    function automatic void set_drive(input logic signed [7:0] l, input logic signed [7:0] r);
        o_result.drive_set = 1'b1; o_result.left_drive = l; o_result.right_drive = r;
    endfunction

    function automatic void set_target(input logic signed [4:0] t);
        o_result.target_set = 1'b1; o_result.speed_target = t;
    endfunction

    function automatic void set_all(input logic signed [4:0] t, input logic signed [7:0] l,
                                    input logic signed [7:0] r, input logic signed [8:0] a);
        set_target(t); set_drive(l, r); set_steer(a);
    endfunction

    // Centering steer used by several modes; mid is the gentle-curve angle.
    function automatic void center(input logic [7:0] v, input logic signed [8:0] mid,
                                   input logic wd);
        case (v & 8'h7E)
            8'h18: begin set_steer(9'sd0); if (wd) set_drive(8'sd100, 8'sd100); end
            8'h1C, 8'h08: begin
                set_steer(9'sd14); if (wd) set_drive(8'sd100, 8'sd100);
            end
            8'h0C: begin
                set_steer(mid + 9'(STEER_TRIM)); if (wd) set_drive(8'sd100, 8'sd100);
            end
            8'h0E, 8'h04: begin set_steer(9'sd36); if (wd) set_drive(8'sd100, 8'sd85); end
            8'h06: begin set_steer(9'sd55); if (wd) set_drive(8'sd100, 8'sd80); end
            8'h02: begin
                set_steer(9'sd80);
                if (wd) begin set_drive(8'sd100, 8'sd70); o_state.mode = M_DRIFT_R; end
            end
            8'h38, 8'h10: begin
                set_steer(-9'sd14); if (wd) set_drive(8'sd100, 8'sd100);
            end
            8'h30: begin
                set_steer(-mid - 9'(STEER_TRIM)); if (wd) set_drive(8'sd100, 8'sd100);
            end
            8'h70, 8'h20: begin set_steer(-9'sd36); if (wd) set_drive(8'sd85, 8'sd100); end
            8'h60: begin set_steer(-9'sd55); if (wd) set_drive(8'sd80, 8'sd100); end
            8'h40: begin
                set_steer(-9'sd80);
                if (wd) begin set_drive(8'sd70, 8'sd100); o_state.mode = M_DRIFT_L; end
            end
            default: ;
        endcase
    endfunction

    always_comb begin
        s = i_item.line_sensors;
        settle_lim = 24'(i_cfg.delay_factor) * 24'd200;
        o_state = i_state;
        o_result = '0;
        o_result.mode_code = i_state.mode;
        unique case (t_cmd'(i_item.cmd))
            CMD_TICK: o_state.tick_count = i_state.tick_count + 16'd1;
            CMD_PULSE: begin
                o_state.pulse_count = i_state.pulse_count + 16'd1;
                o_state.bridge_count = (i_state.mode == M_STRAIGHT)
                    ? i_state.bridge_count + 16'd1 : 16'd0;
            end
            CMD_NONE: ;
            CMD_STEP: begin
                // Mode table; later commands overwrite earlier ones.
                case (i_state.mode)
                    M_STRAIGHT: begin
                        o_result.target_set = 1'b1; o_result.speed_target = 5'sd12;
                        if (s == 8'hFF || (s & 8'h7E) == 8'h7E) begin
                            o_state.mode = M_RA_BRAKE;
                        end else if ((s & 8'hE0) == 8'hE0) begin
                            o_state.mode = M_LC_L;
                            o_state.tick_count = '0; o_state.pulse_count = '0;
                        end else if ((s & 8'h07) == 8'h07) begin
                            o_state.mode = M_LC_R;
                            o_state.tick_count = '0; o_state.pulse_count = '0;
                        end else begin
                            if (i_item.fast_flag && i_state.bridge_count > i_cfg.bridge_limit)
                                o_state.mode = M_BRIDGE;
                            center(s, 9'sd20, 1'b1);
                        end
                    end
                    M_DRIFT_R: begin
                        case (s & 8'hCC)
                            8'hC0: set_all(5'sd6, 8'sd80, -8'sd10, 9'sd150);
                            8'h80: set_all(5'sd6, 8'sd80, 8'sd5, 9'sd130);
                            8'h00: set_all(5'sd8, 8'sd80, 8'sd10, 9'sd95);
                            8'h04: set_all(5'sd10, 8'sd80, 8'sd15, 9'sd70);
                            8'h0C: begin
                                set_all(-5'sd1, 8'sd80, 8'sd20, 9'sd60);
                                o_state.mode = M_STRAIGHT;
                            end
                            default: ;
                        endcase
                    end
                    M_DRIFT_L: begin
                        o_result.target_set = 1'b1; o_result.speed_target = 5'sd10;
                        case (s & 8'h33)
                            8'h03: set_all(5'sd6, -8'sd10, 8'sd80, -9'sd150);
                            8'h01: set_all(5'sd6, 8'sd5, 8'sd80, -9'sd130);
                            8'h00: set_all(5'sd8, 8'sd10, 8'sd80, -9'sd95);
                            8'h20: set_all(5'sd10, 8'sd15, 8'sd80, -9'sd70);
                            8'h30: begin
                                set_all(-5'sd1, 8'sd20, 8'sd80, -9'sd60);
                                o_state.mode = M_STRAIGHT;
                            end
                            default: ;
                        endcase
                    end
                    M_RA_BRAKE: begin
                        set_steer(9'sd0); set_drive(-8'sd40, -8'sd40);
                        o_state.tick_count = '0; o_state.pulse_count = '0;
                        o_state.mode = M_RA_WAIT;
                    end
                    M_RA_WAIT: begin
                        if (i_item.settled_flag) begin
                            set_target(5'sd10); set_drive(8'sd70, 8'sd70);
                            o_state.mode = M_RA_FIND;
                            o_state.tick_count = '0; o_state.pulse_count = '0;
                        end
                        center(s, 9'sd17, 1'b0);
                    end
                    M_RA_FIND: begin
                        if (i_state.pulse_count > 16'd5 && (s & 8'hE0) == 8'hE0) begin
                            set_target(-5'sd1); o_state.mode = M_RA_LEFT;
                            o_state.tick_count = '0;
                        end else if (i_state.pulse_count > 16'd5 && (s & 8'h07) == 8'h07) begin
                            set_target(-5'sd1); o_state.mode = M_RA_RIGHT;
                            o_state.tick_count = '0;
                        end else begin
                            if ((s & 8'h7E) == 8'h00) begin
                                o_state.mode = M_LOST; set_steer(9'sd0);
                                set_drive(8'sd100, 8'sd100);
                                o_state.tick_count = '0; o_state.pulse_count = '0;
                            end
                            center(s, 9'sd17, 1'b0);
                        end
                    end
                    M_RA_LEFT: begin
                        set_steer(-9'sd155); set_drive(-8'sd80, 8'sd80);
                        o_state.mode = M_SPIN_L;
                        o_state.tick_count = '0; o_state.pulse_count = '0;
                    end
                    M_RA_RIGHT: begin
                        set_steer(9'sd155); set_drive(8'sd80, -8'sd80);
                        o_state.mode = M_SPIN_R;
                        o_state.tick_count = '0; o_state.pulse_count = '0;
                    end
                    M_SPIN_L: if (i_state.tick_count > i_cfg.turn_hold) begin
                        o_state.mode = M_SEEK_L;
                        o_state.tick_count = '0; o_state.pulse_count = '0;
                    end
                    M_SEEK_L: if ((s & 8'hE7) == 8'h20) o_state.mode = M_STRAIGHT;
                    M_SPIN_R: if (i_state.tick_count > i_cfg.turn_hold) begin
                        o_state.mode = M_SEEK_R; o_state.tick_count = '0;
                    end
                    M_SEEK_R: if ((s & 8'hE7) == 8'h04) o_state.mode = M_STRAIGHT;
                    M_LC_L, M_LC_R: begin
                        set_target(5'sd10);
                        if ((i_state.mode == M_LC_L && (s & 8'h07) == 8'h07) ||
                            (i_state.mode == M_LC_R && (s & 8'hE0) == 8'hE0)) begin
                            o_state.mode = M_RA_BRAKE; set_target(-5'sd1);
                        end else begin
                            set_drive(8'sd50, 8'sd50);
                            if (i_state.pulse_count >= 16'd25 ||
                                i_state.tick_count >= 16'd120) begin
                                o_state.mode = i_state.mode + 7'd1;
                                o_state.tick_count = '0; o_state.pulse_count = '0;
                            end
                            center(s, 9'sd17, 1'b0);
                        end
                    end
                    M_LC_L_GO: begin
                        set_steer(-9'sd30); set_drive(8'sd35, 8'sd50);
                        o_state.mode = M_LC_L_SET;
                        o_state.tick_count = '0; o_state.pulse_count = '0;
                    end
                    M_LC_R_GO: begin
                        set_steer(9'sd35); set_drive(8'sd50, 8'sd35);
                        o_state.mode = M_LC_R_SET;
                        o_state.tick_count = '0; o_state.pulse_count = '0;
                    end
                    M_LC_L_SET, M_LC_R_SET: begin
                        if ((i_state.pulse_count > 16'd100 ||
                             24'(i_state.tick_count) > settle_lim) &&
                            (s & 8'h30) == 8'h30) begin
                            set_target(-5'sd1);
                            if (i_state.mode == M_LC_L_SET) begin
                                set_steer(9'sd40); set_drive(8'sd100, 8'sd70);
                            end else begin
                                set_steer(-9'sd40); set_drive(8'sd70, 8'sd100);
                            end
                            o_state.mode = M_STRAIGHT;
                        end
                    end
                    M_LOST: begin
                        set_target(5'sd12); set_drive(8'sd60, 8'sd60);
                        if ((s & 8'hC0) == 8'hC0) set_steer(9'sd40);
                        if (s[7]) set_steer(9'sd30);
                        if ((s & 8'h03) == 8'h03) set_steer(-9'sd40);
                        if (s[0]) set_steer(-9'sd30);
                        if ((s & 8'h3C) != 8'h00) begin
                            o_state.mode = M_STRAIGHT; set_target(-5'sd1);
                        end
                    end
                    M_BRIDGE: begin
                        set_drive(-8'sd50, -8'sd50);
                        center(s, 9'sd17, 1'b0);
                        if (i_item.settled_flag) begin
                            set_drive(8'sd70, 8'sd70); o_state.mode = M_STRAIGHT;
                        end
                    end
                    default: o_state.mode = M_STRAIGHT;
                endcase
            end
            default: ;
        endcase
    end

endmodule

>>> src/line_tracking_mode_controller_unit.sv
// Top level of the line tracking mode controller: state and config registers,
// stream handshake and result register. Depends on ltmc_pkg and ltmc_step.
//
// The block takes one beat per clock unless the output register stalls: a
// control step, a 1 ms tick, an encoder pulse or a no-op, and returns exactly
// one result beat for each. The mode, the counters and the result are updated
// at the same edge the input beat is accepted, by a single pass through the
// mode table. A single output register holds the result; a new beat is taken
// whenever that register is empty or is being drained in the same cycle.
// Configuration writes take effect on the next edge and should only be made
// while no beat is in flight.
module line_tracking_mode_controller_unit import ltmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // line_sensors[7:0], fast_flag[8], settled_flag[9], zeros
    input  logic [15:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mode_code[6:0], steer_set[7], steer_angle[16:8], drive_set[17],
    // left_drive[25:18], right_drive[33:26], target_set[34],
    // speed_target[39:35]
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state, n_state;
    t_result r_res, n_res;
    t_item   w_item;
    logic    r_valid;
    logic    w_acc;

    assign w_item = '{cmd: s_axis_tuser, line_sensors: s_axis_tdata[7:0],
                      fast_flag: s_axis_tdata[8], settled_flag: s_axis_tdata[9]};
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    ltmc_step u_step (
        .i_item(w_item), .i_cfg(r_cfg), .i_state(r_state),
        .o_state(n_state), .o_result(n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{delay_factor: 8'd1, bridge_limit: 16'd500, turn_hold: 16'd200};
            r_state <= '{mode: M_STRAIGHT, default: '0};
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DELAY:  r_cfg.delay_factor <= i_cfg_data[7:0];
                    REG_BRIDGE: r_cfg.bridge_limit <= i_cfg_data;
                    REG_HOLD:   r_cfg.turn_hold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_res <= n_res;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = {r_res.speed_target, r_res.target_set, r_res.right_drive,
                           r_res.left_drive, r_res.drive_set, r_res.steer_angle,
                           r_res.steer_set, r_res.mode_code};

    // A held result must not change while the consumer stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A tick or pulse beat never commands anything.
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && s_axis_tuser != CMD_STEP |=>
        !r_res.steer_set && !r_res.drive_set && !r_res.target_set)
        else $error("non-step beat commanded output");

    // The shown mode is the mode held before the beat.
    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_res.mode_code == $past(r_state.mode))
        else $error("shown mode mismatch");

endmodule
